/* hdl/aahg_pkg.sv */
// ----------------------------------------------------------------------------
// aahg_pkg
// Shared types and constants of the alert audio and haptic gate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aahg_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned PowerW = 8;
  localparam int unsigned CfgIdxW = 2;

  // Alert kinds. Codes above the right strong alert are weak alerts.
  localparam logic [KindW-1:0] KIND_NONE      = 3'd0;
  localparam logic [KindW-1:0] KIND_EMERGENCY = 3'd1;
  localparam logic [KindW-1:0] KIND_FRONT     = 3'd2;
  localparam logic [KindW-1:0] KIND_LEFT      = 3'd3;
  localparam logic [KindW-1:0] KIND_RIGHT     = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_AUDIO_LOCKOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_VIB_DURATION  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_VIB_LOCKOUT   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MOTOR_POWER   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [TimeW-1:0]  AudioLockoutRst = 32'd5000;
  localparam logic [TimeW-1:0]  VibDurationRst  = 32'd3000;
  localparam logic [TimeW-1:0]  VibLockoutRst   = 32'd5000;
  localparam logic [PowerW-1:0] MotorPowerRst   = 8'd70;

  typedef struct packed {
    logic [TimeW-1:0]  audio_lockout;
    logic [TimeW-1:0]  vib_duration;
    logic [TimeW-1:0]  vib_lockout;
    logic [PowerW-1:0] motor_power;
  } cfg_t;

  typedef struct packed {
    logic              play_audio;
    logic [KindW-1:0]  audio_kind;
    logic [PowerW-1:0] left_drive;
    logic [PowerW-1:0] right_drive;
  } result_t;

endpackage

`default_nettype wire

/* hdl/alert_audio_haptic_gate.sv */
// ----------------------------------------------------------------------------
// alert_audio_haptic_gate
// Gates audio messages and vibration bursts for a stream of timed alerts.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid_i, in_stall_o, alert_kind_i,     request in
//            now_ms_i
//  result    out_valid_o, out_stall_i, play_audio_o,   request out
//            audio_kind_o, left_drive_o, right_drive_o
//  config    cfg_we_i, cfg_idx_i, cfg_data_i           write only
//
// Each request is held in the input register and leaves through the
// result register; the gate state is updated as it moves between the two.
// One request per cycle is sustained while the result side does not stall.
// Reset restores the register defaults and clears the held alerts.
// A stall on the result side holds the result register, and the input side
// stalls only once the input register is also full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alert_audio_haptic_gate (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [aahg_pkg::KindW-1:0]    alert_kind_i,
  input  wire logic [aahg_pkg::TimeW-1:0]    now_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               play_audio_o,
  output logic [aahg_pkg::KindW-1:0]         audio_kind_o,
  output logic [aahg_pkg::PowerW-1:0]        left_drive_o,
  output logic [aahg_pkg::PowerW-1:0]        right_drive_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [aahg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [aahg_pkg::TimeW-1:0]    cfg_data_i
);
  import aahg_pkg::*;

  cfg_t             cfg;
  result_t          res;
  result_t          res_q;
  logic             s1_valid_q;
  logic [KindW-1:0] s1_kind_q;
  logic [TimeW-1:0] s1_now_q;
  logic             out_valid_q;
  logic             out_free;
  logic             step;
  logic             in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  aahg_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  aahg_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .kind_i   (s1_kind_q),
    .now_i    (s1_now_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (step) begin
        s1_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q <= alert_kind_i;
      s1_now_q  <= now_ms_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign play_audio_o  = res_q.play_audio;
  assign audio_kind_o  = res_q.audio_kind;
  assign left_drive_o  = res_q.left_drive;
  assign right_drive_o = res_q.right_drive;

endmodule

`default_nettype wire

/* hdl/aahg_cfg_regs.sv */
// ----------------------------------------------------------------------------
// aahg_cfg_regs
// Configuration register file: lockout windows, burst length and motor power.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aahg_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [aahg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [aahg_pkg::TimeW-1:0]    cfg_data_i,
  output aahg_pkg::cfg_t                     cfg_o
);
  import aahg_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_AUDIO_LOCKOUT: cfg_d.audio_lockout = cfg_data_i;
        REG_VIB_DURATION:  cfg_d.vib_duration  = cfg_data_i;
        REG_VIB_LOCKOUT:   cfg_d.vib_lockout   = cfg_data_i;
        REG_MOTOR_POWER:   cfg_d.motor_power   = cfg_data_i[PowerW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.audio_lockout <= AudioLockoutRst;
      cfg_q.vib_duration  <= VibDurationRst;
      cfg_q.vib_lockout   <= VibLockoutRst;
      cfg_q.motor_power   <= MotorPowerRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hdl/aahg_core.sv */
// ----------------------------------------------------------------------------
// aahg_core
// Audio and haptic gate decisions with their held state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aahg_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [aahg_pkg::KindW-1:0]  kind_i,
  input  wire logic [aahg_pkg::TimeW-1:0]  now_i,
  input  wire aahg_pkg::cfg_t              cfg_i,
  output aahg_pkg::result_t                result_o
);
  import aahg_pkg::*;

  logic [KindW-1:0] held_audio_q, held_audio_d;
  logic [TimeW-1:0] audio_start_q, audio_start_d;
  logic [KindW-1:0] held_motor_q, held_motor_d;
  logic [TimeW-1:0] burst_start_q, burst_start_d;
  logic [TimeW-1:0] last_burst_q, last_burst_d;
  logic             vibrating_q, vibrating_d;

  logic [TimeW-1:0] audio_elapsed;
  logic [TimeW-1:0] lock_elapsed;
  logic [TimeW-1:0] burst_elapsed;
  logic             is_emerg;
  logic             is_strong;
  logic             audio_ok;
  logic             burst_start;
  logic             in_burst;

  assign audio_elapsed = now_i - audio_start_q;
  assign lock_elapsed  = now_i - last_burst_q;
  assign burst_elapsed = now_i - burst_start_q;
  assign is_emerg      = (kind_i == KIND_EMERGENCY);
  assign is_strong     = (kind_i >= KIND_EMERGENCY) && (kind_i <= KIND_RIGHT);

  always_comb begin
    held_audio_d  = held_audio_q;
    audio_start_d = audio_start_q;
    held_motor_d  = held_motor_q;
    burst_start_d = burst_start_q;
    last_burst_d  = last_burst_q;
    vibrating_d   = vibrating_q;
    result_o      = '0;

    // An emergency breaks through the window unless one is already held.
    audio_ok = (kind_i != KIND_NONE) &&
               ((is_emerg && (held_audio_q != KIND_EMERGENCY)) ||
                !((held_audio_q != KIND_NONE) &&
                  (audio_elapsed < cfg_i.audio_lockout)));
    if (kind_i == KIND_NONE) begin
      held_audio_d  = KIND_NONE;
      audio_start_d = '0;
    end else if (audio_ok) begin
      held_audio_d  = kind_i;
      audio_start_d = now_i;
    end
    result_o.play_audio = audio_ok;
    result_o.audio_kind = audio_ok ? kind_i : KIND_NONE;

    burst_start = is_strong && !vibrating_q &&
                  ((kind_i != held_motor_q) ||
                   (lock_elapsed >= cfg_i.vib_lockout) || is_emerg);
    // A fresh burst has zero elapsed time and so always drives.
    in_burst = burst_start || (burst_elapsed <= cfg_i.vib_duration);

    if (!is_strong) begin
      held_motor_d = KIND_NONE;
      vibrating_d  = 1'b0;
    end else begin
      if (burst_start) begin
        held_motor_d  = kind_i;
        burst_start_d = now_i;
        last_burst_d  = now_i;
      end
      if (burst_start || vibrating_q) begin
        if (in_burst) begin
          vibrating_d = 1'b1;
          case (held_motor_d)
            KIND_EMERGENCY, KIND_FRONT: begin
              result_o.left_drive  = cfg_i.motor_power;
              result_o.right_drive = cfg_i.motor_power;
            end
            KIND_LEFT:  result_o.left_drive  = cfg_i.motor_power;
            KIND_RIGHT: result_o.right_drive = cfg_i.motor_power;
            default: begin
              result_o.left_drive  = '0;
              result_o.right_drive = '0;
            end
          endcase
        end else begin
          vibrating_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_audio_q  <= KIND_NONE;
      audio_start_q <= '0;
      held_motor_q  <= KIND_NONE;
      burst_start_q <= '0;
      last_burst_q  <= '0;
      vibrating_q   <= 1'b0;
    end else if (step_i) begin
      held_audio_q  <= held_audio_d;
      audio_start_q <= audio_start_d;
      held_motor_q  <= held_motor_d;
      burst_start_q <= burst_start_d;
      last_burst_q  <= last_burst_d;
      vibrating_q   <= vibrating_d;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_alert_audio_haptic_gate.sv */
// ----------------------------------------------------------------------------
// tb_alert_audio_haptic_gate
// Self-checking bench for the alert audio and haptic gate. A scoreboard
// predicts the audio and motor outputs for every accepted request and
// compares them in order with the results the gate returns. Directed alerts
// come first, then random alert sequences under several register settings,
// with random gaps and stalls on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_alert_audio_haptic_gate;

  import aahg_pkg::*;

  class gate_scoreboard;
    logic [TimeW-1:0]  audio_window;
    logic [TimeW-1:0]  burst_len;
    logic [TimeW-1:0]  repeat_window;
    logic [PowerW-1:0] drive_level;

    logic [KindW-1:0]  held_audio;
    logic [TimeW-1:0]  audio_t0;
    logic [KindW-1:0]  held_motor;
    logic [TimeW-1:0]  burst_t0;
    logic [TimeW-1:0]  last_burst_t;
    logic              vibrating;

    result_t     due_outputs[$];
    int unsigned n_compared;
    int unsigned n_mismatch;

    function new();
      audio_window  = AudioLockoutRst;
      burst_len     = VibDurationRst;
      repeat_window = VibLockoutRst;
      drive_level   = MotorPowerRst;
      held_audio    = KIND_NONE;
      audio_t0      = '0;
      held_motor    = KIND_NONE;
      burst_t0      = '0;
      last_burst_t  = '0;
      vibrating     = 1'b0;
      n_compared    = 0;
      n_mismatch    = 0;
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] data);
      case (idx)
        REG_AUDIO_LOCKOUT: audio_window  = data;
        REG_VIB_DURATION:  burst_len     = data;
        REG_VIB_LOCKOUT:   repeat_window = data;
        REG_MOTOR_POWER:   drive_level   = data[PowerW-1:0];
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted request and moves the gate state on.
    function void note_alert(input logic [KindW-1:0] kind, input logic [TimeW-1:0] stamp);
      result_t          want;
      logic             sound;
      logic [TimeW-1:0] since_audio;
      logic [TimeW-1:0] since_repeat;
      logic [TimeW-1:0] since_start;
      want = '0;
      since_audio = stamp - audio_t0;
      if (kind == KIND_NONE) begin
        sound = 1'b0;
      end else if (kind == KIND_EMERGENCY && held_audio != KIND_EMERGENCY) begin
        sound = 1'b1;
      end else if (held_audio != KIND_NONE && since_audio < audio_window) begin
        sound = 1'b0;
      end else begin
        sound = 1'b1;
      end
      if (sound) begin
        held_audio = kind;
        audio_t0 = stamp;
        want.play_audio = 1'b1;
        want.audio_kind = kind;
      end

      if (kind < KIND_EMERGENCY || kind > KIND_RIGHT) begin
        held_motor = KIND_NONE;
        vibrating = 1'b0;
      end else begin
        since_repeat = stamp - last_burst_t;
        if (!vibrating && (kind != held_motor || since_repeat >= repeat_window ||
                           kind == KIND_EMERGENCY)) begin
          held_motor = kind;
          burst_t0 = stamp;
          last_burst_t = stamp;
          vibrating = 1'b1;
        end
        if (vibrating) begin
          since_start = stamp - burst_t0;
          if (since_start <= burst_len) begin
            case (held_motor)
              KIND_FRONT, KIND_EMERGENCY: begin
                want.left_drive = drive_level;
                want.right_drive = drive_level;
              end
              KIND_LEFT:  want.left_drive = drive_level;
              KIND_RIGHT: want.right_drive = drive_level;
              default: ;
            endcase
          end else begin
            vibrating = 1'b0;
          end
        end
      end

      // A none alert releases the held audio alert after the gates have run.
      if (kind == KIND_NONE) begin
        held_audio = KIND_NONE;
        audio_t0 = '0;
      end
      due_outputs.push_back(want);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (due_outputs.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: result with nothing outstanding: play %0b kind %0d left %0d right %0d",
                   $realtime, got.play_audio, got.audio_kind, got.left_drive, got.right_drive);
        return;
      end
      want = due_outputs.pop_front();
      n_compared++;
      if (got.play_audio !== want.play_audio || got.audio_kind !== want.audio_kind ||
          got.left_drive !== want.left_drive || got.right_drive !== want.right_drive) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: result %0d differs: play %0b/%0b kind %0d/%0d left %0d/%0d right %0d/%0d (exp/got)",
                   $realtime, n_compared, want.play_audio, got.play_audio, want.audio_kind,
                   got.audio_kind, want.left_drive, got.left_drive, want.right_drive,
                   got.right_drive);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [KindW-1:0]    alert_kind_i;
  logic [TimeW-1:0]    now_ms_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                play_audio_o;
  logic [KindW-1:0]    audio_kind_o;
  logic [PowerW-1:0]   left_drive_o;
  logic [PowerW-1:0]   right_drive_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [TimeW-1:0]    cfg_data_i;

  gate_scoreboard sb = new();

  bit               gaps_on = 1'b1;
  int unsigned      hold_cycles = 0;
  int unsigned      n_sent = 0;
  int unsigned      n_settings = 0;
  int unsigned      stall_seen = 0;
  logic [TimeW-1:0] clock_ms = '0;
  logic [KindW-1:0] last_kind = KIND_FRONT;

  alert_audio_haptic_gate i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .alert_kind_i  (alert_kind_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .play_audio_o  (play_audio_o),
    .audio_kind_o  (audio_kind_o),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Requests are noted before results are checked at the same edge.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni === 1'b1) begin
      if (in_valid_i && !in_stall_o)
        sb.note_alert(alert_kind_i, now_ms_i);
      if (in_valid_i && in_stall_o)
        stall_seen++;
      if (out_valid_o && !out_stall_i) begin
        got.play_audio = play_audio_o;
        got.audio_kind = audio_kind_o;
        got.left_drive = left_drive_o;
        got.right_drive = right_drive_o;
        sb.check_result(got);
      end
    end
  end

  initial begin : result_sink
    int unsigned wait_n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        wait_n = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_n = gaps_on ? $urandom_range(0, 19) : 0;
      end
      if (wait_n != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #3_600_000;
    $display("Run did not drain in time: %0d requests sent, %0d results outstanding.",
             n_sent, sb.due_outputs.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_alert(input logic [KindW-1:0] kind, input logic [TimeW-1:0] stamp);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    alert_kind_i <= kind;
    now_ms_i <= stamp;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.due_outputs.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [TimeW-1:0] audio_lock, input logic [TimeW-1:0] dur,
                            input logic [TimeW-1:0] vib_lock, input logic [PowerW-1:0] power);
    logic [23:0] junk;
    junk = 24'($urandom);
    wait_idle();
    write_reg(REG_AUDIO_LOCKOUT, audio_lock);
    write_reg(REG_VIB_DURATION, dur);
    write_reg(REG_VIB_LOCKOUT, vib_lock);
    // Only the low byte counts for the motor power; the rest is noise.
    write_reg(REG_MOTOR_POWER, {junk, power});
    n_settings++;
  endtask

  // Mostly repeats and changes of strong alerts with advancing time (random
  // under wild_time), so lockout and burst windows are crossed from both sides.
  task automatic run_phase(input int unsigned n_items, input int unsigned step_max,
                           input bit wild_time, input bit allow_idle);
    int unsigned pick;
    logic [KindW-1:0] kind;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (!allow_idle)
        gaps_on = 1'b0;
      else if (i % 32 == 0)
        gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 4)
        kind = last_kind;
      else if (pick < 8)
        kind = KindW'($urandom_range(KIND_EMERGENCY, KIND_RIGHT));
      else if (pick == 8)
        kind = KIND_NONE;
      else
        kind = KindW'($urandom_range(0, 7));
      if (wild_time)
        clock_ms = $urandom;
      else
        clock_ms = clock_ms + $urandom_range(0, step_max);
      last_kind = kind;
      send_alert(kind, clock_ms);
    end
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    alert_kind_i = KIND_NONE;
    now_ms_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_AUDIO_LOCKOUT;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset register values: windows, burst expiry, repeats and wrap.
    send_alert(KIND_NONE, 32'd0);
    send_alert(KIND_EMERGENCY, 32'd0);
    send_alert(KIND_FRONT, 32'd100);
    send_alert(KIND_EMERGENCY, 32'd200);
    send_alert(KIND_LEFT, 32'd3001);
    send_alert(KIND_LEFT, 32'd3002);
    send_alert(KIND_RIGHT, 32'd5000);
    send_alert(3'd5, 32'd5001);
    send_alert(3'd7, 32'd20000);
    send_alert(KIND_NONE, 32'd20001);
    send_alert(KIND_RIGHT, 32'd20002);
    send_alert(KIND_RIGHT, 32'd23003);
    send_alert(KIND_RIGHT, 32'd24000);
    send_alert(KIND_RIGHT, 32'd25002);
    send_alert(3'd6, 32'hFFFF_FF00);
    send_alert(KIND_FRONT, 32'hFFFF_FFF0);
    send_alert(KIND_FRONT, 32'h0000_0010);
    send_alert(KIND_EMERGENCY, 32'hFFFF_FFFF);
    send_alert(KIND_EMERGENCY, 32'h0000_1FA0);
    send_alert(KIND_LEFT, 32'h0000_2000);

    set_config(32'd5000, 32'd3000, 32'd5000, 8'd70);
    clock_ms = 32'hFFFF_0000;
    run_phase(141, 2500, 1'b0, 1'b1);

    set_config(32'd0, 32'd0, 32'd0, 8'd255);
    run_phase(141, 3, 1'b0, 1'b0);

    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1);
    run_phase(141, 1000, 1'b0, 1'b1);

    set_config(32'd20, 32'd10, 32'd30, 8'd128);
    run_phase(141, 15, 1'b0, 1'b1);

    set_config($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
               8'($urandom));
    run_phase(141, 20, 1'b0, 1'b1);

    set_config($urandom, $urandom, $urandom, 8'($urandom));
    run_phase(141, 0, 1'b1, 1'b1);

    // The result side holds off while requests keep coming, so the gate fills.
    set_config(32'd1, 32'd1, 32'd1, 8'd0);
    hold_cycles = 80;
    run_phase(141, 2, 1'b0, 1'b0);

    set_config($urandom_range(0, 2000), $urandom_range(0, 2000), $urandom_range(0, 2000),
               8'($urandom));
    run_phase(141, 700, 1'b0, 1'b1);

    wait_idle();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d alerts under %0d register settings plus the reset values.",
             n_sent, n_settings);
    $display("Compared %0d results; request side held off for %0d cycles; %0d mismatches.",
             sb.n_compared, stall_seen, sb.n_mismatch);
    if (sb.n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
